### src/line_pixel_generator_macros.svh
// Assertion macros for the line pixel generator.
// Included by the RTL files that carry concurrent assertions.
`ifndef LINE_PIXEL_GENERATOR_MACROS_SVH
`define LINE_PIXEL_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LPG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LPG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lpg_pkg.sv
// Package for the line pixel generator: item types, op codes and setup record.
// No dependencies; used by every module of the block.
package lpg_pkg;

  localparam int unsigned COORD_BITS  = 8;
  localparam int unsigned COLOUR_BITS = 8;
  localparam int unsigned ERR_BITS    = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [COLOUR_BITS-1:0] colour_t;
  typedef logic [COORD_BITS:0]    twice_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  // One input item
  typedef struct packed {
    op_e     op;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    colour_t colour;
  } in_item_t;

  // One result item
  typedef struct packed {
    coord_t  pixel_x;
    coord_t  pixel_y;
    colour_t pixel_colour;
    logic    last;
  } out_item_t;

  // Walk set-up worked out from a start item
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    err_t   err;
    twice_t twice_minor;
    twice_t twice_major;
    logic   minor_down;
    logic   y_major;
    coord_t steps;
  } setup_t;

endpackage

### src/lpg_setup.sv
// Line set-up: major axis choice, endpoint ordering and initial error term.
// Purely combinational; depends on lpg_pkg.
module lpg_setup (
  input  lpg_pkg::coord_t x0_i,
  input  lpg_pkg::coord_t y0_i,
  input  lpg_pkg::coord_t x1_i,
  input  lpg_pkg::coord_t y1_i,
  output lpg_pkg::setup_t setup_o
);

  logic [lpg_pkg::COORD_BITS:0] dx, dy;
  lpg_pkg::coord_t adx, ady, major, minor;
  lpg_pkg::coord_t ox0, oy0, ox1, oy1;
  logic y_major, swap;

  // Take absolute deltas
  always_comb begin
    dx  = {1'b0, x1_i} - {1'b0, x0_i};
    dy  = {1'b0, y1_i} - {1'b0, y0_i};
    adx = dx[lpg_pkg::COORD_BITS] ? lpg_pkg::coord_t'(-dx) : dx[lpg_pkg::COORD_BITS-1:0];
    ady = dy[lpg_pkg::COORD_BITS] ? lpg_pkg::coord_t'(-dy) : dy[lpg_pkg::COORD_BITS-1:0];
  end

  // Pick the major axis (ties go to y) and order the endpoints
  always_comb begin
    y_major = !(adx > ady);
    swap    = y_major ? (y0_i > y1_i) : (x0_i > x1_i);
    ox0     = swap ? x1_i : x0_i;
    oy0     = swap ? y1_i : y0_i;
    ox1     = swap ? x0_i : x1_i;
    oy1     = swap ? y0_i : y1_i;
    major   = y_major ? ady : adx;
    minor   = y_major ? adx : ady;
  end

  // Build the walk record
  always_comb begin
    setup_o.cur_x       = ox0;
    setup_o.cur_y       = oy0;
    setup_o.twice_minor = {minor, 1'b0};
    setup_o.twice_major = {major, 1'b0};
    setup_o.err         = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    setup_o.minor_down  = y_major ? (ox1 < ox0) : (oy1 < oy0);
    setup_o.y_major     = y_major;
    setup_o.steps       = major;
  end

endmodule

### src/lpg_walk.sv
// Bresenham walk state: holds the current pixel and error term, steps per advance.
// Depends on lpg_pkg, lpg_setup and the assertion macro header.
`include "line_pixel_generator_macros.svh"

module lpg_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  lpg_pkg::in_item_t   item_i,
  output logic                emit_o,
  output lpg_pkg::out_item_t  pixel_o
);

  lpg_pkg::setup_t setup;

  logic              busy_q, busy_d;
  lpg_pkg::coord_t   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  lpg_pkg::err_t     err_q, err_d;
  lpg_pkg::twice_t   twice_minor_q, twice_minor_d, twice_major_q, twice_major_d;
  logic              minor_down_q, minor_down_d, y_major_q, y_major_d;
  lpg_pkg::coord_t   steps_q, steps_d;
  lpg_pkg::colour_t  colour_q, colour_d;

  lpg_pkg::coord_t   minor_inc;
  logic              err_pos, is_last;

  lpg_setup u_setup (
    .x0_i    (item_i.start_x),
    .y0_i    (item_i.start_y),
    .x1_i    (item_i.end_x),
    .y1_i    (item_i.end_y),
    .setup_o (setup)
  );

  // Present the current pixel
  assign is_last = (steps_q == '0);
  assign emit_o  = (item_i.op == lpg_pkg::OP_ADVANCE) && busy_q;
  assign pixel_o = '{pixel_x: cur_x_q, pixel_y: cur_y_q, pixel_colour: colour_q,
                     last: is_last};

  assign err_pos   = (err_q > 0);
  assign minor_inc = minor_down_q ? '1 : lpg_pkg::coord_t'(1);

  // Next state: when enabled, start sets up, advance steps (or goes idle after the endpoint), otherwise hold
  always_comb begin
    busy_d        = busy_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    err_d         = err_q;
    twice_minor_d = twice_minor_q;
    twice_major_d = twice_major_q;
    minor_down_d  = minor_down_q;
    y_major_d     = y_major_q;
    steps_d       = steps_q;
    colour_d      = colour_q;
    if (step_en_i) begin
      if (item_i.op == lpg_pkg::OP_START) begin
        busy_d        = 1'b1;
        cur_x_d       = setup.cur_x;
        cur_y_d       = setup.cur_y;
        err_d         = setup.err;
        twice_minor_d = setup.twice_minor;
        twice_major_d = setup.twice_major;
        minor_down_d  = setup.minor_down;
        y_major_d     = setup.y_major;
        steps_d       = setup.steps;
        colour_d      = item_i.colour;
      end else if (busy_q) begin
        if (is_last) begin
          busy_d = 1'b0;
        end else begin
          err_d = err_q + $signed({2'b00, twice_minor_q})
                - (err_pos ? $signed({2'b00, twice_major_q}) : lpg_pkg::err_t'(0));
          if (y_major_q) begin
            cur_y_d = cur_y_q + lpg_pkg::coord_t'(1);
            cur_x_d = err_pos ? cur_x_q + minor_inc : cur_x_q;
          end else begin
            cur_x_d = cur_x_q + lpg_pkg::coord_t'(1);
            cur_y_d = err_pos ? cur_y_q + minor_inc : cur_y_q;
          end
          steps_d = steps_q - lpg_pkg::coord_t'(1);
        end
      end
    end
  end

  // Hold walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      err_q         <= '0;
      twice_minor_q <= '0;
      twice_major_q <= '0;
      minor_down_q  <= 1'b0;
      y_major_q     <= 1'b0;
      steps_q       <= '0;
      colour_q      <= '0;
    end else begin
      busy_q        <= busy_d;
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      err_q         <= err_d;
      twice_minor_q <= twice_minor_d;
      twice_major_q <= twice_major_d;
      minor_down_q  <= minor_down_d;
      y_major_q     <= y_major_d;
      steps_q       <= steps_d;
      colour_q      <= colour_d;
    end
  end

  `LPG_ASSERT_NXT(a_start_busy, clk_i, rst_ni,
                  step_en_i && item_i.op == lpg_pkg::OP_START, busy_q,
                  "start item did not arm the walk")
  `LPG_ASSERT_NXT(a_last_idle, clk_i, rst_ni,
                  step_en_i && emit_o && is_last, !busy_q,
                  "walk still busy after the endpoint pixel")
  `LPG_ASSERT_NXT(a_step_count, clk_i, rst_ni,
                  step_en_i && emit_o && !is_last,
                  busy_q && steps_q == $past(steps_q) - lpg_pkg::coord_t'(1),
                  "step count did not drop by one")
  `LPG_ASSERT_NXT(a_idle_holds, clk_i, rst_ni,
                  !busy_q && !(step_en_i && item_i.op == lpg_pkg::OP_START), !busy_q,
                  "walk armed without a start item")

endmodule

### src/line_pixel_generator.sv
// Line pixel generator: Bresenham line engine, one pixel per advance item.
// Channels: input items on in_valid_i/in_stall_o/in_data_i, pixels on
// out_valid_o/out_stall_i/out_data_o; an item moves when valid is high and
// stall is low. A start item (op = start) latches both endpoints and the
// colour and gives no pixel; it abandons any line in progress. Each advance
// item gives one pixel; the endpoint pixel has last set, after which the
// engine is idle and further advances give nothing.
// A pixel passes through the input register, which takes its advance item,
// and then the result register, from which the receiver takes it.
// Throughput: one item per cycle unless a pixel waits on a stalled receiver,
// set by the add, subtract and compare of the error-term update.
// Reset clears both valid flags and leaves the engine idle.
// When the receiver stalls, the pixel holds in the result register; items
// that give no pixel still pass, and an advance waits in the input register,
// raising in_stall_o, until the result register frees.
// Depends on lpg_pkg, lpg_walk and lpg_setup.
module line_pixel_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpg_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpg_pkg::out_item_t  out_data_o
);

  logic               in_valid_q, in_valid_d;
  lpg_pkg::in_item_t  in_q;
  logic               out_valid_q, out_valid_d;
  lpg_pkg::out_item_t out_q;

  logic               emit, out_free, step_en;
  lpg_pkg::out_item_t pixel;

  lpg_walk u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_q),
    .emit_o    (emit),
    .pixel_o   (pixel)
  );

  // Advance the held item when its pixel, if any, has somewhere to go
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_en    = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !step_en;

  assign in_valid_d = in_stall_o ? in_valid_q : in_valid_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_q <= in_data_i;
    end
    if (step_en && emit) begin
      out_q <= pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
